// ===== rtl/dosr_pkg.sv =====
// Package with the item types, commands and sizing constants of the status ring.
package dosr_pkg;

   // Ring sizing: one slot always stays empty, so the ring holds QUEUE_DEPTH-1 entries.
   localparam int QUEUE_DEPTH = 16;
   localparam int ENTRY_WIDTH = 64;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Fixed field widths of the channels.
   localparam int CMD_W   = 2;
   localparam int WORD_W  = 64;
   localparam int OCC_W   = 4;

   // Command codes; the fourth code is unused and changes nothing.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_FLUSH = 2'd2
   } cmd_type;

   // Input item.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [WORD_W-1:0] entry_word;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [WORD_W-1:0] entry_out;
      logic              entry_valid;
      logic              dropped_oldest;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

endpackage

// ===== rtl/drop_oldest_status_ring_core.sv =====
// Top level of the drop-oldest status ring: input register, ring update and result register.
//
//   Channel | Ports                            | Direction | Item
//   --------+----------------------------------+-----------+-------------------------------
//   req     | req_valid, req_ready, req_data   | in        | command and entry word
//   rsp     | rsp_valid, rsp_ready, rsp_data   | out       | entry, flags and occupancy
//
// An item waits in the input register and then moves to the result register, where
// the ring indices and the entry store are updated in the same edge.
// One item per cycle is sustained while the result side does not stall.
// Reset clears both indices and the valid flags; the entry store is not cleared.
// A stalled result holds the input register, and req_ready then drops.
module drop_oldest_status_ring_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dosr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dosr_pkg::rsp_type rsp_data
);

   localparam int IDX_W = dosr_pkg::IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(dosr_pkg::QUEUE_DEPTH - 1);

   // Entry store, written on push and read on pop.
   logic [dosr_pkg::ENTRY_WIDTH-1:0] entry_store [dosr_pkg::QUEUE_DEPTH];

   // Input register stage.
   logic             stage_valid_ff;
   logic             stage_valid_in;
   dosr_pkg::req_type stage_data_ff;

   // Ring indices.
   logic [IDX_W-1:0] write_idx_ff;
   logic [IDX_W-1:0] write_idx_in;
   logic [IDX_W-1:0] read_idx_ff;
   logic [IDX_W-1:0] read_idx_in;

   // Result register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   dosr_pkg::rsp_type rsp_data_ff;

   logic             advance;
   logic             full;
   logic             pop_ok;
   logic             push_op;
   logic             dropped;
   logic [IDX_W-1:0] held;
   logic [IDX_W-1:0] held_after;
   logic [IDX_W-1:0] next_write;
   logic [IDX_W-1:0] next_read;

   // Index advance with wrap at the ring depth.
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
      wrap_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   // Entries held between a read and a write index.
   function automatic logic [IDX_W-1:0] held_count(input logic [IDX_W-1:0] wr,
                                                   input logic [IDX_W-1:0] rd);
      logic [IDX_W:0] diff;
      diff = {1'b0, wr} - {1'b0, rd};
      if (wr < rd) begin
         diff = diff + (IDX_W+1)'(dosr_pkg::QUEUE_DEPTH);
      end
      held_count = diff[IDX_W-1:0];
   endfunction

   // Handshakes: the stage moves on when the result register is free or being taken.
   assign advance        = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready      = !stage_valid_ff || advance;
   assign stage_valid_in = req_valid ? 1'b1 : (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;

   // Ring update for the item in the input register.
   assign held       = held_count(write_idx_ff, read_idx_ff);
   assign full       = (held == LAST_IDX);
   assign next_write = wrap_inc(write_idx_ff);
   assign next_read  = wrap_inc(read_idx_ff);

   always_comb begin
      write_idx_in = write_idx_ff;
      read_idx_in  = read_idx_ff;
      pop_ok       = 1'b0;
      push_op      = 1'b0;
      dropped      = 1'b0;
      case (dosr_pkg::cmd_type'(stage_data_ff.cmd))
         dosr_pkg::CMD_PUSH: begin
            push_op      = 1'b1;
            dropped      = full;
            write_idx_in = next_write;
            if (full) begin
               read_idx_in = next_read;
            end
         end
         dosr_pkg::CMD_POP: begin
            if (read_idx_ff != write_idx_ff) begin
               pop_ok      = 1'b1;
               read_idx_in = next_read;
            end
         end
         dosr_pkg::CMD_FLUSH: begin
            read_idx_in = write_idx_ff;
         end
         default: begin
         end
      endcase
      held_after = held_count(write_idx_in, read_idx_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         write_idx_ff   <= '0;
         read_idx_ff    <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            write_idx_ff <= write_idx_in;
            read_idx_ff  <= read_idx_in;
         end
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_data_ff <= req_data;
      end
   end

   // Entry store write on push.
   always_ff @(posedge clock) begin
      if (advance && push_op) begin
         entry_store[write_idx_ff] <=
            stage_data_ff.entry_word[dosr_pkg::ENTRY_WIDTH-1:0];
      end
   end

   // Result register, with the popped entry read straight from the store.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.entry_out      <= pop_ok ?
            dosr_pkg::WORD_W'(entry_store[read_idx_ff]) : '0;
         rsp_data_ff.entry_valid    <= pop_ok;
         rsp_data_ff.dropped_oldest <= dropped;
         rsp_data_ff.occupancy      <= dosr_pkg::OCC_W'(held_after);
      end
   end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the drop-oldest status ring: random and directed ops on one ring.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   // The fourth command code has no package name; it must change nothing.
   localparam logic [dosr_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int RANDOM_OPS = 1450;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dosr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dosr_pkg::rsp_type rsp_data;

   drop_oldest_status_ring_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Predicted ring contents and indices.
   logic [dosr_pkg::ENTRY_WIDTH-1:0] ring_store [dosr_pkg::QUEUE_DEPTH];
   int unsigned ring_wr = 0;
   int unsigned ring_rd = 0;

   dosr_pkg::req_type ops_pending [$];
   dosr_pkg::rsp_type results_due [$];
   dosr_pkg::rsp_type want;
   int      ops_queued = 0;
   int      ops_taken = 0;
   bit      req_fired = 0;
   bit      steady;
   int      errors = 0;
   int      n_push = 0, n_drop = 0, n_hit = 0, n_empty = 0, n_flush = 0, n_spare = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A stretch in the middle of the run with no idling on either side.
   assign steady = (ops_taken >= 700) && (ops_taken < 1000);

   function automatic int unsigned ring_next(int unsigned i);
      return (i + 1 >= dosr_pkg::QUEUE_DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int unsigned ring_held();
      return (ring_wr + dosr_pkg::QUEUE_DEPTH - ring_rd) % dosr_pkg::QUEUE_DEPTH;
   endfunction

   // Applies one operation to the predicted ring and returns the result it should give.
   function automatic dosr_pkg::rsp_type ring_apply(dosr_pkg::req_type op);
      dosr_pkg::rsp_type r;
      logic [dosr_pkg::WORD_W-1:0] keep;
      keep = (dosr_pkg::ENTRY_WIDTH >= dosr_pkg::WORD_W) ? '1
           : ((64'd1 << dosr_pkg::ENTRY_WIDTH) - 64'd1);
      r = '0;
      case (op.cmd)
         dosr_pkg::CMD_PUSH: begin
            n_push++;
            if (ring_held() >= dosr_pkg::QUEUE_DEPTH - 1) begin
               ring_rd = ring_next(ring_rd);
               r.dropped_oldest = 1'b1;
               n_drop++;
            end
            ring_store[ring_wr] = op.entry_word & keep;
            ring_wr = ring_next(ring_wr);
         end
         dosr_pkg::CMD_POP: begin
            if (ring_rd != ring_wr) begin
               r.entry_out = dosr_pkg::WORD_W'(ring_store[ring_rd]) & keep;
               r.entry_valid = 1'b1;
               ring_rd = ring_next(ring_rd);
               n_hit++;
            end else begin
               n_empty++;
            end
         end
         dosr_pkg::CMD_FLUSH: begin
            ring_rd = ring_wr;
            n_flush++;
         end
         default: begin
            n_spare++;
         end
      endcase
      r.occupancy = dosr_pkg::OCC_W'(ring_held());
      return r;
   endfunction

   function automatic dosr_pkg::req_type make_op(logic [dosr_pkg::CMD_W-1:0] c,
                                                 logic [dosr_pkg::WORD_W-1:0] w);
      dosr_pkg::req_type op;
      op.cmd = c;
      op.entry_word = w;
      return op;
   endfunction

   // Mostly random words, sometimes all zeros, all ones, a walking bit or a walking zero.
   function automatic logic [dosr_pkg::WORD_W-1:0] pick_word();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         return '0;
      if (roll < 6)
         return '1;
      if (roll < 9)
         return 64'd1 << $urandom_range(0, 63);
      if (roll < 12)
         return ~(64'd1 << $urandom_range(0, 63));
      return {$urandom, $urandom};
   endfunction

   task automatic queue_op(dosr_pkg::req_type op);
      ops_pending.push_back(op);
      ops_queued++;
   endtask

   // Waits until every queued item was taken and every result has come back.
   task automatic wait_drained();
      wait (ops_taken == ops_queued);
      wait (results_due.size() == 0);
   endtask

   // Driver: offers the next item at the falling edge, holding it until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (ops_pending.size() > 0 && (steady || $urandom_range(0, 99) >= 36)) begin
            req_valid <= 1'b1;
            req_data <= ops_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The result side stalls at random too.
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= steady || ($urandom_range(0, 99) >= 36);
   end

   // Monitor: checks each result against the oldest prediction, then predicts new items.
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_data);
               errors++;
            end else begin
               want = results_due.pop_front();
               if (rsp_data.entry_out !== want.entry_out) begin
                  $error("entry_out: expected %h, got %h", want.entry_out, rsp_data.entry_out);
                  errors++;
               end
               if (rsp_data.entry_valid !== want.entry_valid) begin
                  $error("entry_valid: expected %b, got %b",
                         want.entry_valid, rsp_data.entry_valid);
                  errors++;
               end
               if (rsp_data.dropped_oldest !== want.dropped_oldest) begin
                  $error("dropped_oldest: expected %b, got %b",
                         want.dropped_oldest, rsp_data.dropped_oldest);
                  errors++;
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_data.occupancy);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            results_due.push_back(ring_apply(req_data));
            ops_taken++;
            req_fired = 1'b1;
         end
      end
   end

   // Stimulus: directed cases, a full drain, then random phases.
   initial begin
      int unsigned mode;
      int unsigned burst;
      int unsigned push_pct;
      int unsigned roll;
      int made;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty ring, unused code, extreme words, pops down to empty and a flush of nothing.
      queue_op(make_op(dosr_pkg::CMD_POP, '1));
      queue_op(make_op(CMD_SPARE, '1));
      queue_op(make_op(dosr_pkg::CMD_PUSH, '0));
      queue_op(make_op(dosr_pkg::CMD_PUSH, '1));
      queue_op(make_op(dosr_pkg::CMD_POP, '0));
      queue_op(make_op(dosr_pkg::CMD_POP, '0));
      queue_op(make_op(dosr_pkg::CMD_POP, '0));
      queue_op(make_op(dosr_pkg::CMD_FLUSH, '1));
      // Fill the ring to its limit, push once more to drop the oldest, then flush it full.
      for (int i = 0; i < dosr_pkg::QUEUE_DEPTH - 1; i++)
         queue_op(make_op(dosr_pkg::CMD_PUSH,
                          (i % 2) ? 64'h5555_5555_5555_5555 ^ (64'd1 << (i * 4))
                                  : 64'hAAAA_AAAA_AAAA_AAAA ^ (64'd1 << (i * 4))));
      queue_op(make_op(dosr_pkg::CMD_PUSH, 64'h8000_0000_0000_0001));
      queue_op(make_op(dosr_pkg::CMD_FLUSH, '0));

      // Hold off until the directed part has fully drained.
      wait_drained();

      // Random phases: filling, draining, balanced and overfilling.
      made = 0;
      while (made < RANDOM_OPS) begin
         mode = $urandom_range(0, 3);
         burst = $urandom_range(20, 60);
         case (mode)
            0: push_pct = 75;
            1: push_pct = 25;
            2: push_pct = 50;
            default: push_pct = 90;
         endcase
         for (int k = 0; k < burst && made < RANDOM_OPS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
               queue_op(make_op(dosr_pkg::CMD_FLUSH, pick_word()));
            else if (roll < 5)
               queue_op(make_op(CMD_SPARE, pick_word()));
            else if (roll < 5 + push_pct * 95 / 100)
               queue_op(make_op(dosr_pkg::CMD_PUSH, pick_word()));
            else
               queue_op(make_op(dosr_pkg::CMD_POP, pick_word()));
            made++;
         end
         if (made >= RANDOM_OPS / 2 && made < RANDOM_OPS / 2 + burst)
            wait_drained();
      end

      wait_drained();
      repeat (6) @(posedge clock);
      $display("Ran %0d items: %0d pushes (%0d dropping the oldest), %0d pops with an entry,",
               ops_taken, n_push, n_drop, n_hit);
      $display("%0d pops on an empty ring, %0d flushes and %0d unused commands.",
               n_empty, n_flush, n_spare);
      if (errors == 0 && results_due.size() == 0) begin
         $display("drop_oldest_status_ring_core test passed");
      end else begin
         $display("drop_oldest_status_ring_core test failed");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #2_000_000;
      $display("drop_oldest_status_ring_core test failed");
      $finish;
   end

endmodule

// ===== drop_oldest_status_ring_core.f =====
rtl/dosr_pkg.sv
rtl/drop_oldest_status_ring_core.sv
tb/tb.sv
